// ----- hw/rtl/pf_pkg.sv -----
// Shared constants and types for the Pareto front filter.
package pf_pkg;

  localparam int PF_MAX_POINTS = 64;
  localparam int PF_OBJ_W      = 32;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_HOLD  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FLUSH = 5'b10000
  } pf_state_t;

  typedef struct packed {
    logic signed [PF_OBJ_W-1:0] second;
    logic signed [PF_OBJ_W-1:0] first;
  } pf_point_t;

endpackage

// ----- hw/rtl/pf_dom_unit.sv -----
// Shared dominance comparator: does the challenger point dominate the held point.
module pf_dom_unit (
  input  pf_pkg::pf_point_t challenger,
  input  pf_pkg::pf_point_t held,
  output logic              dominates
);

  logic first_le, second_le, first_lt, second_lt;

  always_comb begin
    first_le  = challenger.first  <= held.first;
    second_le = challenger.second <= held.second;
    first_lt  = challenger.first  <  held.first;
    second_lt = challenger.second <  held.second;
    // Minimisation: no worse in both objectives and strictly better in one.
    dominates = first_le && second_le && (first_lt || second_lt);
  end

endmodule

// ----- hw/rtl/pf_store.sv -----
// Point memory: one write port for loading, one registered read port for evaluation.
module pf_store #(
  parameter int MAX_POINTS = pf_pkg::PF_MAX_POINTS,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  pf_pkg::pf_point_t wr_data,
  input  logic [AW-1:0]     rd_addr,
  output pf_pkg::pf_point_t rd_data
);

  pf_pkg::pf_point_t mem [MAX_POINTS];
  pf_pkg::pf_point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/pareto_front_filter.sv -----
// Top level of the Pareto front filter: loader, evaluation sequencer and result register.
//
// The block collects a set of two-objective points (signed Q16.16), one point per input
// beat. A beat is taken at a rising edge where start is high and busy is low. A point
// without in_set_end is stored and busy stays low. Once MAX_POINTS points are
// held, further points are dropped and every result of that set shows out_points_dropped.
// The beat with in_set_end closes the set and raises busy for evaluation. Each stored point
// is read back from the point memory and compared against every stored point, one compare
// per cycle through a single shared comparator, the most that the single read port of the
// point memory allows, since each compare needs one point read from it.
// Non-dominated points leave in input order, one result beat per strobe on out_valid,
// each held for one cycle only; the last one carries out_run_final. The receiver cannot
// stall, so results are never held back. Busy falls in the cycle after the final result
// and the block is ready for the next set with its counters cleared. Synchronous reset
// clears the sequencer, the point count and the overflow flag; the memory is not cleared.
module pareto_front_filter #(
  parameter int MAX_POINTS = pf_pkg::PF_MAX_POINTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [pf_pkg::PF_OBJ_W-1:0] in_first_objective,
  input  logic signed [pf_pkg::PF_OBJ_W-1:0] in_second_objective,
  input  logic                               in_set_end,
  output logic                               out_valid,
  output logic signed [pf_pkg::PF_OBJ_W-1:0] out_front_first,
  output logic signed [pf_pkg::PF_OBJ_W-1:0] out_front_second,
  output logic                               out_run_final,
  output logic                               out_points_dropped
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  pf_pkg::pf_state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     j_r, j_nxt;
  logic              dom_r, dom_nxt;
  pf_pkg::pf_point_t cur_r, cur_nxt;
  pf_pkg::pf_point_t pend_r, pend_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic              out_valid_r, out_valid_nxt;
  pf_pkg::pf_point_t out_pt_r, out_pt_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic              mem_we;
  logic [AW-1:0]     rd_addr;
  pf_pkg::pf_point_t wr_data;
  pf_pkg::pf_point_t rd_data;
  logic              dom_hit;
  logic              dom_now;

  assign wr_data.first  = in_first_objective;
  assign wr_data.second = in_second_objective;

  pf_store #(
    .MAX_POINTS(MAX_POINTS),
    .AW        (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  pf_dom_unit u_dom (
    .challenger(rd_data),
    .held      (cur_r),
    .dominates (dom_hit)
  );

  assign busy = (state_r != pf_pkg::S_IDLE) || out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    dom_nxt       = dom_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    pend_vld_nxt  = pend_vld_r;
    out_valid_nxt = 1'b0;
    out_pt_nxt    = out_pt_r;
    out_final_nxt = out_final_r;
    out_drop_nxt  = out_drop_r;
    mem_we        = 1'b0;
    rd_addr       = '0;
    dom_now       = dom_r | dom_hit;

    unique case (state_r)
      pf_pkg::S_IDLE: begin
        if (start && !out_valid_r) begin
          if (count_r < CW'(MAX_POINTS)) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_set_end) begin
            i_nxt     = '0;
            state_nxt = pf_pkg::S_FETCH;
          end
        end
      end
      pf_pkg::S_FETCH: begin
        rd_addr   = i_r[AW-1:0];
        state_nxt = pf_pkg::S_HOLD;
      end
      pf_pkg::S_HOLD: begin
        // Point i is now on the read port; start streaming the set past it.
        cur_nxt   = rd_data;
        rd_addr   = '0;
        j_nxt     = CW'(1);
        dom_nxt   = 1'b0;
        state_nxt = pf_pkg::S_SCAN;
      end
      pf_pkg::S_SCAN: begin
        // The read data holds point j_r - 1, issued in the previous cycle.
        if (j_r < count_r) begin
          rd_addr = j_r[AW-1:0];
          j_nxt   = j_r + 1'b1;
          dom_nxt = dom_now;
        end else begin
          // A survivor can only be known as the last one at the end of the set, so each
          // is parked until the next survivor or the end of the set releases it.
          if (!dom_now) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_pt_nxt    = pend_r;
              out_final_nxt = 1'b0;
              out_drop_nxt  = ovf_r;
            end
            pend_nxt     = cur_r;
            pend_vld_nxt = 1'b1;
          end
          if (i_r == CW'(count_r - 1'b1)) begin
            state_nxt = pf_pkg::S_FLUSH;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = pf_pkg::S_FETCH;
          end
        end
      end
      pf_pkg::S_FLUSH: begin
        out_valid_nxt = 1'b1;
        out_pt_nxt    = pend_r;
        out_final_nxt = 1'b1;
        out_drop_nxt  = ovf_r;
        pend_vld_nxt  = 1'b0;
        count_nxt     = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = pf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pf_pkg::S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    dom_r       <= dom_nxt;
    cur_r       <= cur_nxt;
    pend_r      <= pend_nxt;
    out_pt_r    <= out_pt_nxt;
    out_final_r <= out_final_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_front_first    = out_pt_r.first;
  assign out_front_second   = out_pt_r.second;
  assign out_run_final      = out_final_r;
  assign out_points_dropped = out_drop_r;

endmodule

// ----- hw/rtl/pf_checker.sv -----
// Port-level checker for the Pareto front filter, bound to the top level.
module pf_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_set_end,
  input logic out_valid,
  input logic out_run_final
);

  // Results only appear while the block reports itself busy.
  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while not busy");

  // A point that does not close the set is absorbed without stalling or producing a result.
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_set_end) |=> (!busy && !out_valid))
    else $error("loading beat caused busy or a result");

  // Closing the set starts evaluation.
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_set_end) |=> busy)
    else $error("closing beat did not start evaluation");

  // Nothing follows the final result of a set in the next cycle.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_run_final) |=> !out_valid)
    else $error("result beat after the final one");

endmodule

bind pareto_front_filter pf_checker u_pf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_set_end   (in_set_end),
  .out_valid    (out_valid),
  .out_run_final(out_run_final)
);
